FILE: rtl/core/sabs_pkg.sv
package sabs_pkg;

   localparam int DEPTH_DEF = 256;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FOUND = 2'd1;
   localparam logic [1:0] STATUS_MISS  = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

FILE: rtl/core/sabs_mem.sv
module sabs_mem #(
   parameter int DEPTH = sabs_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  sabs_pkg::mem_ctl_type    mem_ctl,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [31:0]       wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic signed [31:0]       rd_data
);
   import sabs_pkg::*;

   logic signed [31:0] store_ff [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sabs_ctrl.sv
module sabs_ctrl #(
   parameter int DEPTH = sabs_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_position,
   output sabs_pkg::mem_ctl_type    mem_ctl,
   output logic [AW-1:0]            wr_addr,
   output logic signed [31:0]       wr_data,
   output logic [AW-1:0]            rd_addr,
   input  logic signed [31:0]       rd_data
);
   import sabs_pkg::*;

   localparam int PW = (AW > 8) ? AW : 8;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      low_ff, low_in;
   logic [CW-1:0]      top_ff, top_in;
   logic [CW-1:0]      mid_ff, mid_in;
   logic signed [31:0] target_ff, target_in;
   logic [1:0]         pend_status_ff, pend_status_in;
   logic [7:0]         pend_pos_ff, pend_pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_position_ff, rsp_position_in;

   logic               out_free;
   logic               out_load;
   logic               full;
   logic               window_empty;
   logic [CW-1:0]      mid_calc;
   logic [PW-1:0]      pos_wide;
   logic [1:0]         idle_status;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign full         = (count_ff == CW'(DEPTH));
   assign window_empty = (low_ff >= top_ff);
   assign mid_calc     = low_ff + ((top_ff - low_ff - CW'(1)) >> 1);
   assign pos_wide     = PW'(mid_ff[AW-1:0]);

   always_comb begin
      case (req_operation)
         OP_APPEND: idle_status = full ? STATUS_FULL : STATUS_OK;
         OP_SEARCH: idle_status = STATUS_MISS;
         default:   idle_status = STATUS_OK;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_SEARCH) begin
                  state_in = ST_PROBE;
               end else if (!out_free) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PROBE: begin
            state_in = window_empty ? ST_FINISH : ST_CMP;
         end
         ST_CMP: begin
            state_in = (rd_data == target_ff) ? ST_FINISH : ST_PROBE;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in        = count_ff;
      low_in          = low_ff;
      top_in          = top_ff;
      mid_in          = mid_ff;
      target_in       = target_ff;
      pend_status_in  = pend_status_ff;
      pend_pos_in     = pend_pos_ff;
      mem_ctl         = '0;
      out_load        = 1'b0;
      rsp_status_in   = pend_status_ff;
      rsp_position_in = pend_pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            target_in      = req_value;
            low_in         = '0;
            top_in         = count_ff;
            pend_status_in = idle_status;
            pend_pos_in    = '0;
            rsp_status_in  = idle_status;
            rsp_position_in = '0;
            if (req_valid) begin
               if (req_operation == OP_APPEND && !full) begin
                  mem_ctl.wr_en = 1'b1;
                  count_in      = count_ff + CW'(1);
               end else if (req_operation == OP_CLEAR) begin
                  count_in = '0;
               end
               out_load = (req_operation != OP_SEARCH) && out_free;
            end
         end
         ST_PROBE: begin
            mem_ctl.rd_en = !window_empty;
            mid_in        = mid_calc;
         end
         ST_CMP: begin
            if (rd_data == target_ff) begin
               pend_status_in = STATUS_FOUND;
               pend_pos_in    = pos_wide[7:0];
            end else if (rd_data > target_ff) begin
               top_in = mid_ff;
            end else begin
               low_in = mid_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff         <= low_in;
      top_ff         <= top_in;
      mid_ff         <= mid_in;
      target_ff      <= target_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
      if (out_load) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_position_ff <= rsp_position_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign wr_addr      = count_ff[AW-1:0];
   assign wr_data      = req_value;
   assign rd_addr      = mid_calc[AW-1:0];

endmodule

FILE: rtl/core/sorted_array_binary_search.sv
// Sorted-array search block.
// Request channel (req_valid / req_stall) carries an operation and a signed
// 32-bit value: append the value to the store, search the loaded elements
// for it, or clear the store. Each request item gives exactly one response
// item on the rsp_valid / rsp_stall channel: a status and, for a hit, the
// low 8 bits of the matching index.
// Append, clear and the unused selector answer from the idle state; with
// the output register free, the response is valid the cycle after
// acceptance and a new item can be taken every cycle.
// A search runs a probe loop on one shared compare unit: each probe reads
// the store in the probe state and compares and narrows the window in the
// compare state. At most floor(log2(count)) + 1 probes are made, and a miss
// ends in a probe state that finds the window empty; the next item is taken
// at the edge after the response loads.
// req_stall is high while a search is in progress and while a finished
// response waits for a busy output register. While rsp_stall is high the
// response holds; one more item is still taken meanwhile and then waits.
// Reset clears the loaded count and the response valid; the store needs
// no clearing pass since only loaded indices are ever read.
module sorted_array_binary_search #(
   parameter int DEPTH = sabs_pkg::DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_position
);
   import sabs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mem_ctl_type        mem_ctl;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] rd_data;

   sabs_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sabs_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .mem_ctl       (mem_ctl),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

`ifndef SYNTH
   a_pos_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FOUND |-> rsp_position == 8'd0)
      else $error("position nonzero without a hit");

   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_SEARCH |=> req_stall)
      else $error("search did not block the request channel");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

FILE: tb/search_answer_check.sv
module search_answer_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [7:0]         rsp_position,
   output int                 fail_count,
   output int                 pending
);
   import sabs_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] position;
   } answer_type;

   logic signed [31:0] elems [DEPTH_DEF];
   int                 n_loaded;
   answer_type         answers_due [$];
   int                 errs = 0;

   // Apply one item to the local copy of the store and return its answer.
   function automatic answer_type predict_answer(input logic [1:0] op,
                                                 input logic signed [31:0] v);
      answer_type a;
      int         lo;
      int         top;
      int         mid;
      bit         hit;
      a.status   = STATUS_OK;
      a.position = '0;
      case (op)
         OP_APPEND: begin
            if (n_loaded >= DEPTH_DEF) begin
               a.status = STATUS_FULL;
            end else begin
               elems[n_loaded] = v;
               n_loaded++;
            end
         end
         OP_SEARCH: begin
            lo  = 0;
            top = n_loaded;
            hit = 1'b0;
            // window is [lo, top-1]; first matching probe wins, sorted or not
            while (!hit && lo < top) begin
               mid = lo + (top - 1 - lo) / 2;
               if (elems[mid] == v) begin
                  hit        = 1'b1;
                  a.status   = STATUS_FOUND;
                  a.position = mid[7:0];
               end else if (elems[mid] > v) begin
                  top = mid;
               end else begin
                  lo = mid + 1;
               end
            end
            if (!hit)
               a.status = STATUS_MISS;
         end
         OP_CLEAR: n_loaded = 0;
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         n_loaded = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               errs++;
               $display("%0t: unexpected item, expected none, got status %0d position %0d",
                        $time, rsp_status, rsp_position);
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  errs++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_position !== want.position) begin
                  errs++;
                  $display("%0t: position mismatch, expected %0d, got %0d",
                           $time, want.position, rsp_position);
               end
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(predict_answer(req_operation, req_value));
      end
      fail_count <= errs;
      pending    <= answers_due.size();
   end

endmodule

FILE: tb/tb.sv
module tb;
   import sabs_pkg::*;

   localparam logic [1:0]         OP_SPARE  = 2'd3;
   localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX   = 32'sh7FFF_FFFF;
   localparam int                 N_ITEMS   = 1900;
   localparam int                 CALM_FROM = 1700;
   localparam int                 HOLD_AT   = 250;
   localparam int                 HOLD_LEN  = 100;
   localparam int                 LIMIT     = 400000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_position;
   int                 fail_count;
   int                 pending;

   int                 sent = 0;
   int                 cycle_count = 0;
   bit                 calm = 1'b0;
   logic signed [31:0] loaded_vals [$];

   always #5 clock = ~clock;

   sorted_array_binary_search uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position)
   );

   search_answer_check check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("** sorted_array_binary_search: FAILED **");
         $finish;
      end
   end

   function automatic bit idle_window();
      return !calm && (sent / 100) % 3 != 0;
   endfunction

   // Offer one item, with an occasional gap before it, and hold it until taken.
   task automatic send_item(input logic [1:0] op, input logic signed [31:0] v);
      int gap;
      if (idle_window() && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_operation <= op;
      req_value     <= v;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
      calm = sent >= CALM_FROM;
      case (op)
         OP_APPEND: if (loaded_vals.size() < DEPTH_DEF) loaded_vals.push_back(v);
         OP_CLEAR:  loaded_vals.delete();
         default: ;
      endcase
   endtask

   // Append n ascending values, spread over the whole range or packed densely.
   task automatic load_sorted(input int n, input bit dense);
      longint             cur;
      longint             span;
      logic signed [31:0] v;
      if (dense) begin
         cur  = ($urandom_range(0, 3) == 0) ? longint'(VAL_MIN)
                                            : longint'($urandom_range(0, 2000)) - 1000;
         span = 3;
      end else begin
         cur  = longint'(VAL_MIN);
         span = longint'(32'hFFFF_FFFF) / (n + 1);
      end
      repeat (n) begin
         // leave a few steps at zero for duplicates
         if ($urandom_range(0, 7) != 0)
            cur += $urandom_range(0, int'(span));
         v = cur[31:0];
         send_item(OP_APPEND, v);
      end
   endtask

   task automatic run_searches(input int k);
      int                 r;
      int                 idx;
      logic signed [31:0] t;
      repeat (k) begin
         r   = $urandom_range(0, 5);
         idx = (loaded_vals.size() > 0) ? $urandom_range(0, loaded_vals.size() - 1) : 0;
         if (r < 3 && loaded_vals.size() > 0)
            t = loaded_vals[idx];
         else if (r == 3 && loaded_vals.size() > 0)
            t = loaded_vals[idx] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
         else if (r == 5)
            case ($urandom_range(0, 3))
               0: t = VAL_MIN;
               1: t = VAL_MAX;
               2: t = 32'sd0;
               default: t = -32'sd1;
            endcase
         else
            t = $urandom;
         send_item(OP_SEARCH, t);
      end
   endtask

   // Response side: random stall bursts, one long hold to back the block up.
   initial begin
      bit held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && sent >= HOLD_AT) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN) @(negedge clock);
            held = 1'b1;
         end else if (idle_window() && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   initial begin
      int r;
      int n;
      int fills;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_APPEND;
      req_value     = '0;
      fills         = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, unused selector, extremes, clear, unsorted store
      send_item(OP_SEARCH, 32'sd0);
      send_item(OP_SPARE, -32'sd1);
      send_item(OP_APPEND, VAL_MIN);
      send_item(OP_APPEND, -32'sd1);
      send_item(OP_APPEND, 32'sd0);
      send_item(OP_APPEND, 32'sd1);
      send_item(OP_APPEND, VAL_MAX);
      send_item(OP_SEARCH, VAL_MIN);
      send_item(OP_SEARCH, -32'sd1);
      send_item(OP_SEARCH, 32'sd0);
      send_item(OP_SEARCH, 32'sd1);
      send_item(OP_SEARCH, VAL_MAX);
      send_item(OP_SEARCH, 32'sd7);
      send_item(OP_SEARCH, -32'sd2);
      send_item(OP_CLEAR, 32'sd0);
      send_item(OP_SEARCH, 32'sd0);
      send_item(OP_APPEND, 32'sd5);
      send_item(OP_APPEND, 32'sd3);
      send_item(OP_APPEND, -32'sd4);
      send_item(OP_SEARCH, 32'sd3);
      send_item(OP_SEARCH, -32'sd4);
      send_item(OP_SEARCH, 32'sd5);
      send_item(OP_CLEAR, -32'sd1);

      while (sent < N_ITEMS) begin
         if ((fills == 0 && sent >= 600) || (fills == 1 && sent >= 1300)) begin
            // fill the store, push past it, then search the full range
            fills++;
            send_item(OP_CLEAR, $urandom);
            load_sorted(DEPTH_DEF, fills == 2);
            repeat ($urandom_range(2, 4)) send_item(OP_APPEND, $urandom);
            run_searches(20);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               if ($urandom_range(0, 5) != 0)
                  send_item(OP_CLEAR, $urandom);
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
               load_sorted(n, $urandom_range(0, 2) == 0);
               run_searches($urandom_range(3, 12));
            end else if (r < 75) begin
               send_item(OP_CLEAR, $urandom);
               repeat ($urandom_range(2, 10)) send_item(OP_APPEND, $urandom);
               run_searches($urandom_range(3, 8));
            end else if (r < 88) begin
               repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), $urandom);
            end else begin
               run_searches($urandom_range(1, 6));
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** sorted_array_binary_search: PASSED **");
      else
         $display("** sorted_array_binary_search: FAILED **");
      $finish;
   end

endmodule

FILE: sorted_array_binary_search.f
rtl/core/sabs_pkg.sv
rtl/core/sabs_mem.sv
rtl/core/sabs_ctrl.sv
rtl/core/sorted_array_binary_search.sv
tb/search_answer_check.sv
tb/tb.sv
